// File: src/vlcp_pkg.sv
`default_nettype none

package vlcp_pkg;

    // fixed field widths
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    // op queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // one op for the packing stage: code bits already masked to len
    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// File: src/vlcp_if.sv
`default_nettype none

interface vlcp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  symbol;
    logic [31:0] code_value;
    logic [5:0]  code_length;

    modport source (output valid, output kind, output symbol, output code_value,
                    output code_length, input ready);
    modport sink   (input valid, input kind, input symbol, input code_value,
                    input code_length, output ready);
endinterface

interface vlcp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: src/vlcp_front.sv
`default_nettype none

module vlcp_front #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    vlcp_in_if.sink                      in_ch,
    input  wire vlcp_pkg::queue_status_t q_status,
    output logic                         push,
    output vlcp_pkg::op_t                push_op
);

    localparam int CAP     = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W = CAP + vlcp_pkg::LEN_W;
    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOL_COUNT);
    localparam logic [vlcp_pkg::LEN_W-1:0] CAP_LEN = vlcp_pkg::LEN_W'(CAP);

    logic [ENTRY_W-1:0] mem [SYMBOL_COUNT];
    logic [ENTRY_W-1:0] rdata_reg;

    logic s1_valid_reg, s1_valid_next;
    logic s1_flush_reg, s1_flush_next;

    logic                       accept;
    logic                       sym_ok;
    logic [ADDR_W-1:0]          addr;
    logic                       wr_en;
    logic                       rd_en;
    logic                       take_op;
    logic [vlcp_pkg::LEN_W-1:0] sat_len;
    logic [CAP-1:0]             code_mask;
    logic [CAP-1:0]             wr_bits;

    assign in_ch.ready = !s1_valid_reg || !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign sym_ok      = {1'b0, in_ch.symbol} < SYM_LIMIT;
    assign addr        = in_ch.symbol[ADDR_W-1:0];

    // saturate and mask at load time so the read side is a plain lookup
    assign sat_len   = (in_ch.code_length > CAP_LEN) ? CAP_LEN : in_ch.code_length;
    assign code_mask = CAP'(~({(CAP + 1){1'b1}} << sat_len));
    assign wr_bits   = in_ch.code_value[CAP-1:0] & code_mask;

    assign wr_en   = accept && (in_ch.kind == vlcp_pkg::KIND_LOAD) && sym_ok;
    assign rd_en   = accept && (in_ch.kind == vlcp_pkg::KIND_ENCODE) && sym_ok;
    assign take_op = rd_en || (accept && (in_ch.kind == vlcp_pkg::KIND_FLUSH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= {sat_len, wr_bits};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (push)
        begin
            s1_valid_next = 1'b0;
        end
        if (take_op)
        begin
            s1_valid_next = 1'b1;
            s1_flush_next = (in_ch.kind == vlcp_pkg::KIND_FLUSH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_flush_reg <= s1_flush_next;
    end

    assign push          = s1_valid_reg && !q_status.full;
    assign push_op.flush = s1_flush_reg;
    assign push_op.len   = s1_flush_reg ? '0 : rdata_reg[ENTRY_W-1 -: vlcp_pkg::LEN_W];
    assign push_op.bits  = vlcp_pkg::CODE_W'(rdata_reg[CAP-1:0]);

endmodule

`default_nettype wire

// File: src/vlcp_queue.sv
`default_nettype none

module vlcp_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire vlcp_pkg::op_t           push_op,
    input  wire logic                    pop,
    output vlcp_pkg::op_t                head,
    output vlcp_pkg::queue_status_t      q_status
);

    vlcp_pkg::op_t entry_reg [vlcp_pkg::QUEUE_DEPTH];

    logic [vlcp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vlcp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vlcp_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    logic do_push;
    logic do_pop;

    assign q_status.full  = (cnt_reg == vlcp_pkg::QUEUE_CNT_W'(vlcp_pkg::QUEUE_DEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == vlcp_pkg::QUEUE_PTR_W'(vlcp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vlcp_pkg::QUEUE_PTR_W'(vlcp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: src/vlcp_back.sv
`default_nettype none

module vlcp_back #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire vlcp_pkg::op_t           head,
    input  wire vlcp_pkg::queue_status_t q_status,
    output logic                         pop,
    vlcp_out_if.source                   out_ch
);

    localparam int CAP = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
    localparam int W   = CAP + 7;
    localparam int CW  = $clog2(W + 1);

    logic [W-1:0]  work_reg, work_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;

    logic          out_free;
    logic          emit_enc;
    logic [CW-1:0] rem_cnt;
    logic [W-1:0]  rem_mask;
    logic [W-1:0]  enc_shift;
    logic [CW-1:0] eff_cnt;
    logic [W-1:0]  eff_bits;
    logic          idle;
    logic [7:0]    flush_byte;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ch.ready;
        rem_cnt   = cnt_reg - CW'(8);
        enc_shift = work_reg >> rem_cnt;
        rem_mask  = ~({W{1'b1}} << rem_cnt);
        emit_enc  = (cnt_reg >= CW'(8)) && out_free;
        eff_cnt   = emit_enc ? rem_cnt : cnt_reg;
        eff_bits  = emit_enc ? (work_reg & rem_mask) : work_reg;
        idle      = eff_cnt < CW'(8);
        // left-justify the pending bits, zero padding below
        flush_byte = 8'(16'(eff_bits[6:0]) << (4'd8 - {1'b0, eff_cnt[2:0]}));

        work_next      = eff_bits;
        cnt_next       = eff_cnt;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (emit_enc)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = enc_shift[7:0];
            // fewer than eight bits left after this byte: item is done
            out_last_next  = ({1'b0, cnt_reg} < (CW + 1)'(16));
        end

        if (idle && !q_status.empty)
        begin
            if (!head.flush)
            begin
                pop       = 1'b1;
                work_next = (W'(eff_bits[6:0]) << head.len) | W'(head.bits[CAP-1:0]);
                cnt_next  = eff_cnt + CW'(head.len);
            end
            else if (!emit_enc && ((eff_cnt == '0) || out_free))
            begin
                pop       = 1'b1;
                work_next = '0;
                cnt_next  = '0;
                if (eff_cnt != '0)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = flush_byte;
                    out_last_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            work_reg      <= work_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

endmodule

`default_nettype wire

// File: src/variable_length_code_packer.sv
`default_nettype none

// channel   dir   handshake      payload
// in_ch     in    valid/ready    kind, symbol, code_value, code_length
// out_ch    out   valid/ready    out_byte, last
//
// loads, unused kinds stop at the table; flushes and byteless encodes do not hold the packer
// an encode item that completes k bytes (at most 4) holds the packer until its last byte,
// emitting one byte per cycle into the output register while out_ch is not stalled
// an item reaches the packer through the table read register, then the op queue
// the code table is not cleared by reset; entries are valid once loaded
// a full queue with an op in lookup drops in_ch.ready; a stalled out_ch holds the packer

module variable_length_code_packer #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vlcp_in_if.sink    in_ch,
    vlcp_out_if.source out_ch
);

    // front to queue
    logic                    push;
    vlcp_pkg::op_t           push_op;
    // queue to back
    logic                    pop;
    vlcp_pkg::op_t           head;
    vlcp_pkg::queue_status_t q_status;

    // code table lookup, kind decode and symbol range check
    vlcp_front #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    // short op queue decoupling lookup from packing
    vlcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // bit accumulator and byte emit
    vlcp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

// File: src/vlcp_checker.sv
`default_nettype none

module vlcp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // a waiting output item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item withdrawn while stalled");

    // its payload does not change while stalled
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
        else $error("output payload changed while stalled");

    // nothing comes out right after reset
    a_reset_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output item right after reset");

    // the input side is open right after reset
    a_reset_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind variable_length_code_packer vlcp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
);

`default_nettype wire
